// ===== rtl/svp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_pkg - sample voice playback shared definitions
// Item codes, register indexes, divide-by-constant figures and the control
// group that steers the scaling lanes.
// ----------------------------------------------------------------------------
package svp_pkg;

  // item codes carried on req_type
  typedef enum logic [2:0] {
    REQ_WRITE  = 3'd0,
    REQ_START  = 3'd1,
    REQ_STOP   = 3'd2,
    REQ_SETVOL = 3'd3,
    REQ_TICK   = 3'd4
  } req_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SAMPLE_COUNT  = 3'd0,
    CFG_TWO_CHANNEL   = 3'd1,
    CFG_LINEAR_INTERP = 3'd2,
    CFG_STEREO_OUTPUT = 3'd3,
    CFG_PAN           = 3'd4,
    CFG_LOOP_ENABLE   = 3'd5,
    CFG_STEP          = 3'd6
  } cfg_idx_t;

  localparam int CFG_W = 22;

  // pan scale and volume scale divisors
  localparam logic [13:0] PAN_FULL = 14'd10000;
  localparam logic [13:0] DIV_PAN  = 14'd10000;
  localparam logic [13:0] DIV_VOL  = 14'd127;

  // floor(2^32 / divisor): the quotient estimate is low by at most one
  localparam logic [25:0] RCP_PAN = 26'((64'd1 << 32) / 64'd10000);
  localparam logic [25:0] RCP_VOL = 26'((64'd1 << 32) / 64'd127);

  typedef enum logic {
    SEL_PAN = 1'b0,
    SEL_VOL = 1'b1
  } div_sel_t;

  typedef struct packed {
    logic     en;
    div_sel_t sel;
  } scale_ctl_t;

endpackage

// ===== rtl/svp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module svp_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/svp_urem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_urem - iterative unsigned remainder
// Restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module svp_urem (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [17:0] dividend,
  input  logic [16:0] divisor,
  output logic        busy,
  output logic [16:0] rem
);

  localparam int STEPS = 18;

  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [17:0] dvd_r;
  logic [16:0] dsr_r;
  logic [16:0] rem_r;
  logic [17:0] trial;
  logic [17:0] rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[17]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = trial - {1'b0, dsr_r};
    end else begin
      rem_nxt = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'(STEPS - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[16:0], 1'b0};
      rem_r <= rem_nxt[16:0];
    end
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/svp_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_scale - product over constant, truncated toward zero
// Three-stage lane: a*k, reciprocal estimate, remainder correction.
// ----------------------------------------------------------------------------
module svp_scale
  import svp_pkg::*;
(
  input  logic               clk,
  input  scale_ctl_t         ctl,
  input  logic signed [15:0] a,
  input  logic [13:0]        k,
  output logic signed [15:0] q
);

  logic signed [30:0] prod;
  logic [28:0]        mag0_r;
  logic               neg0_r;
  div_sel_t           sel0_r;

  logic [25:0] rcp;
  logic [54:0] est;
  logic [28:0] mag1_r;
  logic [15:0] q0_r;
  logic        neg1_r;
  div_sel_t    sel1_r;

  logic [13:0] dsr;
  logic [28:0] qd;
  logic [28:0] rmd;
  logic [15:0] qc;
  logic [16:0] qs;
  logic signed [15:0] q_r;

  assign prod = a * $signed({1'b0, k});
  assign rcp  = (sel0_r == SEL_VOL) ? RCP_VOL : RCP_PAN;
  assign est  = 55'(mag0_r) * 55'(rcp);
  assign dsr  = (sel1_r == SEL_VOL) ? DIV_VOL : DIV_PAN;
  assign qd   = 29'(q0_r) * 29'(dsr);
  assign rmd  = mag1_r - qd;
  assign qc   = (rmd >= 29'(dsr)) ? q0_r + 16'd1 : q0_r;
  assign qs   = neg1_r ? (~{1'b0, qc} + 17'd1) : {1'b0, qc};

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      neg0_r <= prod[30];
      mag0_r <= prod[30] ? 29'(-prod) : prod[28:0];
      sel0_r <= ctl.sel;
      mag1_r <= mag0_r;
      neg1_r <= neg0_r;
      sel1_r <= sel0_r;
      q0_r   <= est[47:32];
      q_r    <= $signed(qs[15:0]);
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/sample_voice_playback_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_voice_playback_unit - one wavetable sample playback voice
// Sample words live in a local RAM; each tick item renders one output pair
// from the Q17.16 play position, with volume scaling and, for mono data, pan.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  req_type, addr, wdata, volume
//   out_     output     out_valid / out_stall left, right, playing, reverb_path
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// Write, start, stop and set-volume items leave the input unstalled. A tick
// item walks through the single RAM read port and the two three-stage
// scaling lanes, each run for pan (mono data only), then volume. When the
// interpolation partner reaches the sample count, the tick also waits on
// the bit-serial remainder unit. An idle tick goes straight to its result.
// Reset is synchronous; the sample RAM is not cleared. A stalled result
// holds the sequencer in its last step; input is stalled while a tick runs.
// ----------------------------------------------------------------------------
module sample_voice_playback_unit
  import svp_pkg::*;
#(
  parameter int SAMPLE_WORDS = 65536  // power of two, 256 to 1048576
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic [15:0]        in_addr,
  input  logic signed [15:0] in_wdata,
  input  logic [6:0]         in_volume,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_right,
  output logic               out_playing,
  output logic               out_reverb_path,

  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(SAMPLE_WORDS);
  localparam int EW = (AW > 18) ? AW : 18;

  // tick sequencer
  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_T0     = 13'b0000000000010,
    ST_MOD    = 13'b0000000000100,
    ST_RDB    = 13'b0000000001000,
    ST_MIX    = 13'b0000000010000,
    ST_INTERP = 13'b0000000100000,
    ST_PAN_GO = 13'b0000001000000,
    ST_PAN_W1 = 13'b0000010000000,
    ST_PAN_W2 = 13'b0000100000000,
    ST_VOL_GO = 13'b0001000000000,
    ST_VOL_W1 = 13'b0010000000000,
    ST_VOL_W2 = 13'b0100000000000,
    ST_DONE   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [16:0]        count_r;
  logic               two_ch_r;
  logic               interp_r;
  logic               st_out_r;
  logic [14:0]        pan_r;
  logic               loop_r;
  logic [21:0]        step_r;

  // voice state
  logic [32:0]        pos_r;
  logic [6:0]         cur_vol_r;
  logic [6:0]         tgt_vol_r;
  logic               active_r;

  // datapath holding registers
  logic               idle_r;
  logic [16:0]        partner_r;
  logic signed [15:0] s_r;
  logic signed [15:0] s2_r;
  logic signed [34:0] prod_r;
  logic signed [15:0] sint_r;

  // result register
  logic               out_valid_r;
  logic signed [15:0] out_left_r;
  logic signed [15:0] out_right_r;
  logic               out_playing_r;
  logic               out_rev_r;

  logic               in_acc;
  req_t               req;
  logic               addr_ok;
  logic               live;
  logic               out_free;

  logic [16:0]        idx;
  logic [17:0]        part_inc;
  logic               part_fast;
  logic               need_mod;

  logic               ram_we;
  logic               ram_re;
  logic [EW-1:0]      raddr_w;
  logic [15:0]        ram_rdata;
  logic signed [15:0] rd_s;

  logic               rem_start;
  logic               rem_busy;
  logic [16:0]        rem_val;

  logic signed [16:0] diff;
  logic signed [16:0] frac_s;
  logic signed [34:0] mul_w;
  logic signed [34:0] num;
  logic signed [34:0] num_adj;

  logic [14:0]        pan_abs;
  logic [13:0]        pan_sat;
  logic [13:0]        lp;
  logic [13:0]        rp;

  scale_ctl_t         sc_ctl;
  logic signed [15:0] sc_a_l, sc_a_r;
  logic [13:0]        sc_k_l, sc_k_r;
  logic signed [15:0] q_l, q_r;

  logic [16:0]        end_w;
  logic [32:0]        pos_sum;
  logic               at_end;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign req       = req_t'(in_req_type);
  assign addr_ok   = (32'(in_addr) < SAMPLE_WORDS);
  assign live      = active_r && (count_r != '0);
  assign out_free  = !out_valid_r || !out_stall;

  assign idx       = pos_r[32:16];
  assign part_inc  = {1'b0, idx} + 18'd1;
  assign part_fast = (part_inc < {1'b0, count_r});
  assign need_mod  = live && !two_ch_r && interp_r && !part_fast;
  assign rem_start = (state_r == ST_T0) && need_mod;

  // ---- sample memory -------------------------------------------------------
  // Read A in the first tick step (frame left word or the sample itself),
  // read B once the partner index is known (frame right word or partner).
  assign ram_we = in_acc && (req == REQ_WRITE) && addr_ok;
  assign ram_re = (state_r == ST_T0) || (state_r == ST_RDB);

  always_comb begin
    if (state_r == ST_RDB) begin
      raddr_w = two_ch_r ? EW'({idx, 1'b1}) : EW'(partner_r);
    end else begin
      raddr_w = two_ch_r ? EW'({idx, 1'b0}) : EW'(idx);
    end
  end

  svp_ram #(
    .WIDTH (16),
    .DEPTH (SAMPLE_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_addr)),
    .wdata (in_wdata),
    .re    (ram_re),
    .raddr (raddr_w[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_s = $signed(ram_rdata);

  // ---- partner index wrap: (idx + 1) mod sample_count -----------------------
  svp_urem u_urem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (part_inc),
    .divisor  (count_r),
    .busy     (rem_busy),
    .rem      (rem_val)
  );

  // ---- linear interpolation -------------------------------------------------
  // s + (s2 - s) * frac / 65536, truncated toward zero
  assign diff    = 17'(rd_s) - 17'(s_r);
  assign frac_s  = $signed({1'b0, pos_r[15:0]});
  assign mul_w   = diff * frac_s;
  assign num     = ($signed(35'(s_r)) <<< 16) + prod_r;
  assign num_adj = num[34] ? (num + 35'sd65535) : num;

  // ---- pan weights on the 10000 scale ---------------------------------------
  assign pan_abs = pan_r[14] ? (~pan_r + 15'd1) : pan_r;
  assign pan_sat = (pan_abs > 15'(PAN_FULL)) ? PAN_FULL : pan_abs[13:0];
  assign lp      = (st_out_r && !pan_r[14]) ? (PAN_FULL - pan_sat) : PAN_FULL;
  assign rp      = (st_out_r && pan_r[14])  ? (PAN_FULL - pan_sat) : PAN_FULL;

  // ---- scaling lanes --------------------------------------------------------
  // Both lanes run pan first, then volume; stereo frames skip the pan pass.
  // Hold the lanes while the result waits so their output stays put.
  always_comb begin
    sc_ctl.en = (state_r != ST_DONE);
    if (state_r == ST_VOL_GO) begin
      sc_ctl.sel = SEL_VOL;
      sc_a_l     = two_ch_r ? s_r  : q_l;
      sc_a_r     = two_ch_r ? s2_r : q_r;
      sc_k_l     = {7'd0, cur_vol_r};
      sc_k_r     = {7'd0, cur_vol_r};
    end else begin
      sc_ctl.sel = SEL_PAN;
      sc_a_l     = sint_r;
      sc_a_r     = sint_r;
      sc_k_l     = lp;
      sc_k_r     = rp;
    end
  end

  svp_scale u_scale_l (
    .clk (clk),
    .ctl (sc_ctl),
    .a   (sc_a_l),
    .k   (sc_k_l),
    .q   (q_l)
  );

  svp_scale u_scale_r (
    .clk (clk),
    .ctl (sc_ctl),
    .a   (sc_a_r),
    .k   (sc_k_r),
    .q   (q_r)
  );

  // ---- position advance and end of data ------------------------------------
  assign end_w   = two_ch_r ? {1'b0, count_r[16:1]} : count_r;
  assign pos_sum = pos_r + 33'(step_r);
  assign at_end  = (pos_sum >= {end_w, 16'd0});

  // ---- sequencer ------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (req == REQ_TICK)) begin
          state_nxt = ST_T0;
        end
      end
      ST_T0: begin
        if (!live) begin
          state_nxt = ST_DONE;
        end else if (need_mod) begin
          state_nxt = ST_MOD;
        end else begin
          state_nxt = ST_RDB;
        end
      end
      ST_MOD: begin
        if (!rem_busy) begin
          state_nxt = ST_RDB;
        end
      end
      ST_RDB:    state_nxt = ST_MIX;
      ST_MIX:    state_nxt = two_ch_r ? ST_VOL_GO : ST_INTERP;
      ST_INTERP: state_nxt = ST_PAN_GO;
      ST_PAN_GO: state_nxt = ST_PAN_W1;
      ST_PAN_W1: state_nxt = ST_PAN_W2;
      ST_PAN_W2: state_nxt = ST_VOL_GO;
      ST_VOL_GO: state_nxt = ST_VOL_W1;
      ST_VOL_W1: state_nxt = ST_VOL_W2;
      ST_VOL_W2: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // ---- control registers ----------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      two_ch_r    <= 1'b0;
      interp_r    <= 1'b0;
      st_out_r    <= 1'b1;
      pan_r       <= '0;
      loop_r      <= 1'b0;
      step_r      <= 22'd65536;
      pos_r       <= '0;
      cur_vol_r   <= '0;
      tgt_vol_r   <= 7'd127;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SAMPLE_COUNT:  count_r  <= cfg_wdata[16:0];
          CFG_TWO_CHANNEL:   two_ch_r <= cfg_wdata[0];
          CFG_LINEAR_INTERP: interp_r <= cfg_wdata[0];
          CFG_STEREO_OUTPUT: st_out_r <= cfg_wdata[0];
          CFG_PAN:           pan_r    <= cfg_wdata[14:0];
          CFG_LOOP_ENABLE:   loop_r   <= cfg_wdata[0];
          CFG_STEP:          step_r   <= cfg_wdata[21:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        case (req)
          REQ_START: begin
            cur_vol_r <= in_volume;
            tgt_vol_r <= in_volume;
            pos_r     <= '0;
            active_r  <= 1'b1;
          end
          REQ_STOP:   active_r  <= 1'b0;
          REQ_SETVOL: tgt_vol_r <= in_volume;
          default: ;
        endcase
      end

      // ramp the volume one step toward its target on each rendered tick
      if ((state_r == ST_T0) && live) begin
        if (cur_vol_r < tgt_vol_r) begin
          cur_vol_r <= cur_vol_r + 7'd1;
        end else if (cur_vol_r > tgt_vol_r) begin
          cur_vol_r <= cur_vol_r - 7'd1;
        end
      end

      // advance, wrap at the end and drop out unless looping
      if ((state_r == ST_DONE) && out_free && !idle_r) begin
        if (at_end) begin
          pos_r <= '0;
          if (!loop_r) begin
            active_r <= 1'b0;
          end
        end else begin
          pos_r <= pos_sum;
        end
      end

      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- datapath registers ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == ST_T0) begin
      idle_r    <= !live;
      partner_r <= part_inc[16:0];
    end
    if ((state_r == ST_MOD) && !rem_busy) begin
      partner_r <= rem_val;
    end
    if (state_r == ST_RDB) begin
      s_r <= rd_s;
    end
    if (state_r == ST_MIX) begin
      s2_r   <= rd_s;
      prod_r <= mul_w;
    end
    if (state_r == ST_INTERP) begin
      sint_r <= interp_r ? num_adj[31:16] : s_r;
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_left_r    <= idle_r ? 16'sd0 : q_l;
      out_right_r   <= idle_r ? 16'sd0 : q_r;
      out_playing_r <= idle_r ? active_r : (!at_end || loop_r);
      out_rev_r     <= !idle_r && !two_ch_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left        = out_left_r;
  assign out_right       = out_right_r;
  assign out_playing     = out_playing_r;
  assign out_reverb_path = out_rev_r;

endmodule

// ===== verif/svp_playback_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svp_playback_checker - voice prediction and result checking
// Watches the item, result and register ports of the playback voice. It keeps
// its own copy of the sample memory, the play position, the volume ramp and
// the registers. From these it predicts the output pair of every tick item,
// then checks each delivered pair against the oldest prediction.
// ----------------------------------------------------------------------------
module svp_playback_checker
  import svp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_req_type,
  input  logic [15:0]        in_addr,
  input  logic signed [15:0] in_wdata,
  input  logic [6:0]         in_volume,

  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_left,
  input  logic signed [15:0] out_right,
  input  logic               out_playing,
  input  logic               out_reverb_path,

  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,

  output int unsigned        mismatch_count,
  output int unsigned        pairs_pending,
  output int unsigned        pairs_checked
);

  localparam int MEM_WORDS = 65536;
  localparam int PAN_SCALE = 10000;
  localparam int VOL_SCALE = 127;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               playing;
    logic               reverb;
  } voice_pair_t;

  logic signed [15:0] voice_mem [MEM_WORDS];
  voice_pair_t        predicted_pairs[$];
  int unsigned        fails;

  // voice state
  logic [32:0] play_pos;
  logic [6:0]  cur_vol;
  logic [6:0]  tgt_vol;
  logic        voice_on;

  // register copies
  logic [16:0]        n_words;
  logic               stereo_data;
  logic               interp_on;
  logic               pan_on;
  logic               loop_on;
  logic signed [14:0] pan_set;
  logic [21:0]        pos_rate;

  function automatic int vol_scaled(int x);
    return (x * int'(cur_vol)) / VOL_SCALE;
  endfunction

  // Render one tick: ramp, read, interpolate and pan mono data, scale, then advance the position.
  function automatic voice_pair_t render_tick();
    voice_pair_t pair;
    logic [16:0] idx;
    longint      end_words;
    int          s;
    int          s2;
    int          lp;
    int          rp;
    int          mag;
    longint      num;
    pair = '0;
    if (voice_on && n_words != 0) begin
      idx = play_pos[32:16];
      if (cur_vol < tgt_vol) begin
        cur_vol++;
      end else if (cur_vol > tgt_vol) begin
        cur_vol--;
      end
      if (stereo_data) begin
        pair.left  = 16'(vol_scaled(voice_mem[16'(idx * 2)]));
        pair.right = 16'(vol_scaled(voice_mem[16'(idx * 2 + 1)]));
        end_words  = n_words / 2;
      end else begin
        s = voice_mem[idx[15:0]];
        if (interp_on) begin
          s2  = voice_mem[16'((int'(idx) + 1) % int'(n_words))];
          num = longint'(s) * 65536 + longint'(s2 - s) * longint'(play_pos[15:0]);
          s   = int'(num / 65536);
        end
        lp = PAN_SCALE;
        rp = PAN_SCALE;
        if (pan_on) begin
          mag = (pan_set < 0) ? -int'(pan_set) : int'(pan_set);
          if (mag > PAN_SCALE) mag = PAN_SCALE;
          if (pan_set < 0) begin
            rp = PAN_SCALE - mag;
          end else if (pan_set > 0) begin
            lp = PAN_SCALE - mag;
          end
        end
        pair.left   = 16'(vol_scaled((s * lp) / PAN_SCALE));
        pair.right  = 16'(vol_scaled((s * rp) / PAN_SCALE));
        pair.reverb = 1'b1;
        end_words   = n_words;
      end
      play_pos = play_pos + 33'(pos_rate);
      if (longint'(play_pos) >= (end_words << 16)) begin
        play_pos = '0;
        if (!loop_on) voice_on = 1'b0;
      end
    end
    pair.playing = voice_on;
    return pair;
  endfunction

  function automatic void flag_pair(string why, voice_pair_t want, voice_pair_t got);
    fails++;
    if (fails <= REPORT_MAX) begin
      $display("%0t: %s: expected L=%0d R=%0d playing=%0b reverb=%0b, got L=%0d R=%0d playing=%0b reverb=%0b",
               $realtime, why, want.left, want.right, want.playing, want.reverb,
               got.left, got.right, got.playing, got.reverb);
    end
  endfunction

  always @(posedge clk) begin
    voice_pair_t got;
    voice_pair_t want;
    if (!rst_n) begin
      play_pos    = '0;
      cur_vol     = '0;
      tgt_vol     = 7'd127;
      voice_on    = 1'b0;
      n_words     = '0;
      stereo_data = 1'b0;
      interp_on   = 1'b0;
      pan_on      = 1'b1;
      loop_on     = 1'b0;
      pan_set     = '0;
      pos_rate    = 22'h10000;
      predicted_pairs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SAMPLE_COUNT:  n_words     = cfg_wdata[16:0];
          CFG_TWO_CHANNEL:   stereo_data = cfg_wdata[0];
          CFG_LINEAR_INTERP: interp_on   = cfg_wdata[0];
          CFG_STEREO_OUTPUT: pan_on      = cfg_wdata[0];
          CFG_PAN:           pan_set     = cfg_wdata[14:0];
          CFG_LOOP_ENABLE:   loop_on     = cfg_wdata[0];
          CFG_STEP:          pos_rate    = cfg_wdata[21:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (req_t'(in_req_type))
          REQ_WRITE:  voice_mem[in_addr] = in_wdata;
          REQ_START: begin
            cur_vol  = in_volume;
            tgt_vol  = in_volume;
            play_pos = '0;
            voice_on = 1'b1;
          end
          REQ_STOP:   voice_on = 1'b0;
          REQ_SETVOL: tgt_vol = in_volume;
          REQ_TICK:   predicted_pairs.push_back(render_tick());
          default: ;  // drop unknown codes
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {out_left, out_right, out_playing, out_reverb_path};
        pairs_checked <= pairs_checked + 1;
        if (predicted_pairs.size() == 0) begin
          flag_pair("pair with nothing predicted", '0, got);
        end else begin
          want = predicted_pairs.pop_front();
          if (got !== want) flag_pair("pair mismatch", want, got);
        end
      end
    end
    mismatch_count <= fails;
    pairs_pending  <= predicted_pairs.size();
  end

endmodule

// ===== verif/sample_voice_playback_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_voice_playback_unit_tb - playback voice testbench
// Fills part of the sample memory, runs a short directed sequence over the
// idle, end-of-data, pan and interpolation corner cases, then a dozen random
// register setups with mixed item traffic under three idling patterns. The
// checker beside the block predicts and compares every output pair.
// ----------------------------------------------------------------------------
module sample_voice_playback_unit_tb
  import svp_pkg::*;
();

  // About 1600 items; a correct run, stalls included, ends within the cycle
  // limit.
  localparam int CYCLE_LIMIT     = 800_000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int PREFIX_WORDS    = 256;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 110;

  localparam logic [2:0]         REQ_CODE_MAX  = '1;
  localparam logic [16:0]        WORDS_ALL     = 17'h10000;
  localparam logic [15:0]        WORD_MOST_NEG = 16'h8000;
  localparam logic [15:0]        WORD_MOST_POS = 16'h7FFF;
  localparam logic signed [14:0] PAN_MOST_NEG  = {1'b1, 14'b0};
  localparam logic signed [14:0] PAN_MOST_POS  = {1'b0, {14{1'b1}}};
  localparam logic [21:0]        RATE_UNITY    = 22'h10000;

  typedef struct {
    logic [16:0]        words;
    logic               two_ch;
    logic               interp;
    logic               pan_on;
    logic signed [14:0] pan;
    logic               looping;
    logic [21:0]        rate;
  } voice_setup_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_req_type = REQ_TICK;
  logic [15:0]        in_addr = '0;
  logic signed [15:0] in_wdata = '0;
  logic [6:0]         in_volume = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  logic               out_playing;
  logic               out_reverb_path;

  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  int unsigned        mismatch_count;
  int unsigned        pairs_pending;
  int unsigned        pairs_checked;

  int                 snd_idle_pct = 13;
  int                 rcv_idle_pct = 55;
  int unsigned        cycle_count = 0;
  int unsigned        n_items = 0;
  int unsigned        n_ticks = 0;
  int unsigned        n_writes = 0;
  int unsigned        n_setups = 0;

  sample_voice_playback_unit i_dut (.*);

  svp_playback_checker i_chk (.*);

  always #2 clk = ~clk;

  // Receiver back-pressure: stall at random with the current percentage.
  always @(posedge clk) begin
    out_stall <= (rcv_idle_pct > 0) && ($urandom_range(0, 99) < rcv_idle_pct);
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run exceeded %0d cycles with %0d pairs outstanding", CYCLE_LIMIT, pairs_pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] any16();
    return 16'($urandom());
  endfunction

  // Offer one item, idling beforehand at random; hold it until accepted.
  task automatic send_item(input logic [2:0] req, input logic [15:0] addr,
                           input logic [15:0] word, input logic [6:0] vol);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_addr     <= addr;
    in_wdata    <= word;
    in_volume   <= vol;
    do @(posedge clk); while (in_stall);
    n_items++;
    if (req == REQ_TICK) n_ticks++;
    if (req == REQ_WRITE) n_writes++;
  endtask

  // Drop valid and wait until every predicted pair has come out, then let
  // a tick still in flight finish before touching the registers.
  task automatic settle_voice();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pairs_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic program_voice(input voice_setup_t v);
    settle_voice();
    write_reg(CFG_SAMPLE_COUNT, CFG_W'(v.words));
    write_reg(CFG_TWO_CHANNEL, CFG_W'(v.two_ch));
    write_reg(CFG_LINEAR_INTERP, CFG_W'(v.interp));
    write_reg(CFG_STEREO_OUTPUT, CFG_W'(v.pan_on));
    // sign-extend the pan: only the low 15 bits may count
    write_reg(CFG_PAN, CFG_W'(v.pan));
    write_reg(CFG_LOOP_ENABLE, CFG_W'(v.looping));
    write_reg(CFG_STEP, v.rate);
    cfg_we <= 1'b0;
    n_setups++;
  endtask

  // Random setup; a few phases are pinned to register extremes. The sample
  // count, or at full span the low rate, keeps reads in the filled prefix.
  function automatic voice_setup_t random_setup(int phase);
    voice_setup_t v;
    v.words   = 17'($urandom_range(1, PREFIX_WORDS));
    v.two_ch  = 1'($urandom());
    v.interp  = 1'($urandom());
    v.pan_on  = ($urandom_range(0, 3) != 0);
    v.looping = 1'($urandom());
    if ($urandom_range(0, 5) == 0) begin
      v.pan = '0;
    end else if ($urandom_range(0, 3) == 0) begin
      v.pan = 15'($urandom());
    end else begin
      v.pan = 15'($urandom_range(0, 20000) - 10000);
    end
    if ($urandom_range(0, 4) == 0) begin
      v.rate = 22'($urandom());
    end else begin
      v.rate = 22'($urandom_range(1 << 12, 3 << 16));
    end
    case (phase)
      0: begin
        v.words = PREFIX_WORDS;
        v.rate  = '1;
      end
      3: begin
        // full memory span: keep the rate low so reads stay in the prefix
        v.words = WORDS_ALL;
        v.rate  = 22'($urandom_range(1, 1 << 15));
      end
      5: v.pan = PAN_MOST_POS;
      6: v.words = 17'd1;
      9: v.rate = '0;
      10: v.words = '0;
      default: ;
    endcase
    return v;
  endfunction

  task automatic run_mixed_traffic(input int n);
    int unsigned pick;
    logic [15:0] addr;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      addr = ($urandom_range(0, 3) == 0) ? any16() : 16'($urandom_range(0, PREFIX_WORDS - 1));
      if (pick < 56) begin
        send_item(REQ_TICK, any16(), any16(), 7'($urandom()));
      end else if (pick < 74) begin
        send_item(REQ_WRITE, addr, any16(), 7'($urandom()));
      end else if (pick < 84) begin
        send_item(REQ_SETVOL, any16(), any16(), 7'($urandom()));
      end else if (pick < 91) begin
        send_item(REQ_START, any16(), any16(), 7'($urandom()));
      end else if (pick < 96) begin
        send_item(REQ_STOP, any16(), any16(), 7'($urandom()));
      end else begin
        send_item(3'($urandom_range(REQ_TICK + 1, REQ_CODE_MAX)), any16(), any16(),
                  7'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the low words, with both extremes at the bottom.
    for (int a = 0; a < PREFIX_WORDS; a++) begin
      send_item(REQ_WRITE, 16'(a),
                (a == 0) ? WORD_MOST_NEG : (a == 1) ? WORD_MOST_POS : any16(),
                7'($urandom()));
    end

    // Idle tick while stopped, then a started voice with no sample count.
    send_item(REQ_TICK, any16(), any16(), 7'($urandom()));
    send_item(REQ_START, any16(), any16(), 7'd127);
    send_item(REQ_TICK, any16(), any16(), 7'($urandom()));
    for (int c = REQ_TICK + 1; c <= REQ_CODE_MAX; c++) begin
      send_item(3'(c), any16(), any16(), 7'($urandom()));
    end

    // Nearest sample, pan beyond full scale, run off the end and stop.
    program_voice('{words: 17'd4, two_ch: 1'b0, interp: 1'b0, pan_on: 1'b1,
                    pan: PAN_MOST_NEG, looping: 1'b0, rate: RATE_UNITY});
    send_item(REQ_START, any16(), any16(), 7'd127);
    repeat (5) send_item(REQ_TICK, any16(), any16(), 7'($urandom()));

    // Interpolation with the partner wrapping to word zero, looping, a
    // volume ramp from silence, then stop and an idle tick.
    program_voice('{words: 17'd3, two_ch: 1'b0, interp: 1'b1, pan_on: 1'b0,
                    pan: 15'(PAN_FULL), looping: 1'b1, rate: 22'h14000});
    send_item(REQ_START, any16(), any16(), 7'd0);
    send_item(REQ_SETVOL, any16(), any16(), 7'd127);
    repeat (4) send_item(REQ_TICK, any16(), any16(), 7'($urandom()));
    send_item(REQ_STOP, any16(), any16(), 7'($urandom()));
    send_item(REQ_TICK, any16(), any16(), 7'($urandom()));

    // Stereo frames, odd word count, fastest rate.
    program_voice('{words: 17'd5, two_ch: 1'b1, interp: 1'b0, pan_on: 1'b1,
                    pan: '0, looping: 1'b0, rate: '1});
    send_item(REQ_START, any16(), any16(), 7'd64);
    repeat (2) send_item(REQ_TICK, any16(), any16(), 7'($urandom()));

    // Random setups: swap the idling sides after four, then run clean.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 4) begin
        snd_idle_pct <= 55;
        rcv_idle_pct <= 13;
      end else if (phase == 8) begin
        snd_idle_pct <= 0;
        rcv_idle_pct <= 0;
      end
      program_voice(random_setup(phase));
      // restart so the position lies within the new data
      send_item(REQ_START, any16(), any16(), 7'($urandom()));
      run_mixed_traffic(ITEMS_PER_PHASE);
    end

    settle_voice();
    $display("Drove %0d items (%0d ticks, %0d sample writes) across %0d register setups",
             n_items, n_ticks, n_writes, n_setups);
    $display("and three idling patterns; %0d output pairs checked, %0d mismatched.",
             pairs_checked, mismatch_count);
    if (mismatch_count == 0 && pairs_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sample_voice_playback_unit.f =====
rtl/svp_pkg.sv
rtl/svp_ram.sv
rtl/svp_urem.sv
rtl/svp_scale.sv
rtl/sample_voice_playback_unit.sv
verif/svp_playback_checker.sv
verif/sample_voice_playback_unit_tb.sv
